// ----- hdl/art_pkg.sv -----
// Shared types and constants for the arena reservation table.
`default_nettype none
package art_pkg;
    localparam int ENTRIES_DEF       = 16;
    localparam int DEFAULT_ALIGN_DEF = 8;
    localparam int AW                = 35;  // address datapath width, never wraps

    localparam logic [1:0] OP_FIRST   = 2'd0;
    localparam logic [1:0] OP_AT      = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOSPACE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PASS,
        S_RD,
        S_CMP,
        S_PLACE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic hit;
        logic fits;
    } t_hit_res;
endpackage
`default_nettype wire

// ----- hdl/art_ifs.sv -----
// Handshake interfaces for request, result and configuration channels.
`default_nettype none
interface art_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] req_size;
    logic [31:0] req_alignment;
    logic [31:0] req_offset;
    logic        req_exclusive;
    logic [31:0] release_id;
    logic        release_held;
    modport source (output valid, opcode, req_size, req_alignment, req_offset,
                    req_exclusive, release_id, release_held, input ready);
    modport sink   (input valid, opcode, req_size, req_alignment, req_offset,
                    req_exclusive, release_id, release_held, output ready);
endinterface

interface art_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] res_id;
    logic [31:0] res_offset;
    logic [31:0] res_size;
    logic        res_exclusive;
    logic [31:0] available_bytes;
    modport source (output valid, status, res_id, res_offset, res_size,
                    res_exclusive, available_bytes, input ready);
    modport sink   (input valid, status, res_id, res_offset, res_size,
                    res_exclusive, available_bytes, output ready);
endinterface

interface art_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] pool_size;
    modport source (output valid, pool_size, input ready);
    modport sink   (input valid, pool_size, output ready);
endinterface
`default_nettype wire

// ----- hdl/art_hit.sv -----
// Shared overlap / fit / round-up unit, evaluated once per table entry.
`default_nettype none
module art_hit (
    input  wire logic [art_pkg::AW-1:0] i_at,
    input  wire logic [31:0]            i_size,
    input  wire logic [31:0]            i_pool,
    input  wire logic [31:0]            i_e_start,
    input  wire logic [31:0]            i_e_len,
    input  wire logic [31:0]            i_align_m1,
    output art_pkg::t_hit_res           o_res,
    output logic [art_pkg::AW-1:0]      o_next_at
);
    import art_pkg::*;

    logic [AW-1:0] e_start, e_end, at_end, pool, am1;

    always_comb begin
        e_start   = {3'b0, i_e_start};
        e_end     = e_start + {3'b0, i_e_len};
        at_end    = i_at + {3'b0, i_size};
        pool      = {3'b0, i_pool};
        am1       = {3'b0, i_align_m1};
        o_res.hit  = (i_at < e_end) && (e_start < at_end);
        o_res.fits = (i_at <= pool) && ({3'b0, i_size} <= pool - i_at);
        o_next_at = (e_end + am1) & ~am1;
    end
endmodule
`default_nettype wire

// ----- hdl/art_table.sv -----
// Reservation entry storage: id/start/length memory plus valid flops.
`default_nettype none
module art_table #(
    parameter int ENTRIES = art_pkg::ENTRIES_DEF,
    parameter int IW      = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_clear,
    input  wire logic [IW-1:0] i_rd_idx,
    input  wire logic          i_wr_en,
    input  wire logic [IW-1:0] i_wr_idx,
    input  wire logic [31:0]   i_wr_id,
    input  wire logic [31:0]   i_wr_start,
    input  wire logic [31:0]   i_wr_len,
    input  wire logic          i_inv_en,
    output logic [31:0]        o_rd_id,
    output logic [31:0]        o_rd_start,
    output logic [31:0]        o_rd_len,
    output logic               o_rd_valid,
    output logic               o_free_found,
    output logic [IW-1:0]      o_free_idx
);
    import art_pkg::*;

    logic [31:0]        mem_id    [ENTRIES];
    logic [31:0]        mem_start [ENTRIES];
    logic [31:0]        mem_len   [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_id[i_wr_idx]    <= i_wr_id;
            mem_start[i_wr_idx] <= i_wr_start;
            mem_len[i_wr_idx]   <= i_wr_len;
        end
        o_rd_id    <= mem_id[i_rd_idx];
        o_rd_start <= mem_start[i_rd_idx];
        o_rd_len   <= mem_len[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else begin
            if (i_wr_en)  r_valid[i_wr_idx] <= 1'b1;
            if (i_inv_en) r_valid[i_rd_idx] <= 1'b0;
        end
    end

    assign o_rd_valid = r_valid[i_rd_idx];

    // lowest free slot
    always_comb begin
        o_free_found = 1'b0;
        o_free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                o_free_found = 1'b1;
                o_free_idx   = IW'(i);
            end
        end
    end
endmodule
`default_nettype wire

// ----- hdl/arena_reservation_table.sv -----
// Arena reservation table top level: sequencer, result register, free-byte count.
// Sequence: validate (S_CHECK); each pass is S_PASS, then S_RD and S_CMP per scanned entry;
//   first fit runs up to ENTRIES+1 passes, fixed offset one pass, release one scan with no
//   pass state; reserves add S_PLACE; all end in S_OUT, held while the result is stalled.
// Flow: one item at a time; a new beat is taken only in S_IDLE, after the result beat.
// Reset: synchronous active low; table empty, ids start at 1, pool size 0.
`default_nettype none
module arena_reservation_table #(
    parameter int ENTRIES       = art_pkg::ENTRIES_DEF,
    parameter int DEFAULT_ALIGN = art_pkg::DEFAULT_ALIGN_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    art_in_if.sink     i_in,
    art_out_if.source  o_out,
    art_cfg_if.sink    i_cfg
);
    import art_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = $clog2(ENTRIES + 2);
    localparam int UW = 32 + $clog2(ENTRIES + 1);   // sum of all lengths

    t_state r_state, n_state;

    // latched request
    logic [1:0]    r_op;
    logic [31:0]   r_size, r_align, r_offs, r_rid;
    logic          r_excl, r_held;
    // scan state
    logic [AW-1:0] r_at, n_at;
    logic [PW-1:0] r_pass, n_pass;
    logic [IW-1:0] r_idx, n_idx;
    // pool bookkeeping
    logic [31:0]   r_pool;
    logic [UW-1:0] r_used, n_used;
    logic [31:0]   r_next_id, n_next_id;
    // result beat
    logic [1:0]    r_status, n_status;
    logic [31:0]   r_res_id, n_res_id, r_res_off, n_res_off, r_res_size, n_res_size;
    logic          r_res_excl, n_res_excl;

    logic          in_beat, cfg_beat;
    logic [31:0]   align_eff, align_m1;
    logic          last_idx;

    // table / unit hookups
    logic          tb_wr_en, tb_inv_en, tb_rd_valid, tb_free_found;
    logic [IW-1:0] tb_free_idx;
    logic [31:0]   tb_rd_id, tb_rd_start, tb_rd_len;
    t_hit_res      hu_res;
    logic [AW-1:0] hu_next_at;

    assign in_beat  = i_in.valid && i_in.ready;
    assign cfg_beat = i_cfg.valid && i_cfg.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // alignment zero selects default
    assign align_eff = (r_align == 32'd0) ? 32'(DEFAULT_ALIGN) : r_align;
    assign align_m1  = align_eff - 32'd1;
    assign last_idx  = (r_idx == IW'(ENTRIES - 1));

    art_table #(.ENTRIES(ENTRIES), .IW(IW)) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (cfg_beat),
        .i_rd_idx     (r_idx),
        .i_wr_en      (tb_wr_en),
        .i_wr_idx     (tb_free_idx),
        .i_wr_id      (r_next_id),
        .i_wr_start   (r_at[31:0]),
        .i_wr_len     (r_size),
        .i_inv_en     (tb_inv_en),
        .o_rd_id      (tb_rd_id),
        .o_rd_start   (tb_rd_start),
        .o_rd_len     (tb_rd_len),
        .o_rd_valid   (tb_rd_valid),
        .o_free_found (tb_free_found),
        .o_free_idx   (tb_free_idx)
    );

    art_hit u_hit (
        .i_at       (r_at),
        .i_size     (r_size),
        .i_pool     (r_pool),
        .i_e_start  (tb_rd_start),
        .i_e_len    (tb_rd_len),
        .i_align_m1 (align_m1),
        .o_res      (hu_res),
        .o_next_at  (hu_next_at)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_beat) n_state = S_CHECK;
            S_CHECK: begin
                if (r_op == OP_RELEASE && r_held) begin
                    n_state = S_RD;
                end else if ((r_op == OP_FIRST || r_op == OP_AT) && r_pool != 32'd0 &&
                             r_size != 32'd0 && (align_eff & align_m1) == 32'd0 &&
                             !(r_op == OP_AT && (r_offs & align_m1) != 32'd0)) begin
                    n_state = S_PASS;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_PASS:  n_state = (hu_res.fits && r_pass <= PW'(ENTRIES)) ? S_RD : S_OUT;
            S_RD:    n_state = S_CMP;
            S_CMP: begin
                if (r_op == OP_RELEASE) begin
                    if (tb_rd_valid && tb_rd_id == r_rid) n_state = S_OUT;
                    else if (last_idx)                    n_state = S_OUT;
                    else                                  n_state = S_RD;
                end else if (tb_rd_valid && hu_res.hit) begin
                    n_state = (r_op == OP_AT) ? S_OUT : S_PASS;
                end else begin
                    n_state = last_idx ? S_PLACE : S_RD;
                end
            end
            S_PLACE: n_state = S_OUT;
            S_OUT:   if (o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_at       = r_at;
        n_pass     = r_pass;
        n_idx      = r_idx;
        n_used     = r_used;
        n_next_id  = r_next_id;
        n_status   = r_status;
        n_res_id   = r_res_id;
        n_res_off  = r_res_off;
        n_res_size = r_res_size;
        n_res_excl = r_res_excl;
        tb_wr_en   = 1'b0;
        tb_inv_en  = 1'b0;
        case (r_state)
            S_CHECK: begin
                // failures and releases carry a zero reservation
                n_status   = ST_INVALID;
                n_res_id   = '0;
                n_res_off  = '0;
                n_res_size = '0;
                n_res_excl = 1'b0;
                n_idx      = '0;
                n_at       = (r_op == OP_AT) ? {3'b0, r_offs} : '0;
                n_pass     = (r_op == OP_AT) ? PW'(ENTRIES) : '0;
            end
            S_PASS: begin
                n_idx    = '0;
                n_status = ST_NOSPACE;
            end
            S_CMP: begin
                if (r_op == OP_RELEASE) begin
                    if (tb_rd_valid && tb_rd_id == r_rid) begin
                        tb_inv_en = 1'b1;
                        n_used    = r_used - UW'(tb_rd_len);
                        n_status  = ST_OK;
                    end else if (!last_idx) begin
                        n_idx = r_idx + IW'(1);
                    end
                end else if (tb_rd_valid && hu_res.hit) begin
                    // jump past the blocking entry
                    n_at   = hu_next_at;
                    n_pass = r_pass + PW'(1);
                end else if (!last_idx) begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_PLACE: begin
                if (tb_free_found) begin
                    tb_wr_en   = 1'b1;
                    n_used     = r_used + UW'(r_size);
                    n_next_id  = r_next_id + 32'd1;
                    n_status   = ST_OK;
                    n_res_id   = r_next_id;
                    n_res_off  = r_at[31:0];
                    n_res_size = r_size;
                    n_res_excl = r_excl;
                end else begin
                    n_status = ST_FULL;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pool    <= '0;
            r_used    <= '0;
            r_next_id <= 32'd1;
        end else begin
            r_state <= n_state;
            if (cfg_beat) begin
                r_pool    <= i_cfg.pool_size;
                r_used    <= '0;
                r_next_id <= 32'd1;
            end else begin
                r_used    <= n_used;
                r_next_id <= n_next_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_op    <= i_in.opcode;
            r_size  <= i_in.req_size;
            r_align <= i_in.req_alignment;
            r_offs  <= i_in.req_offset;
            r_excl  <= i_in.req_exclusive;
            r_rid   <= i_in.release_id;
            r_held  <= i_in.release_held;
        end
        r_at       <= n_at;
        r_pass     <= n_pass;
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_res_id   <= n_res_id;
        r_res_off  <= n_res_off;
        r_res_size <= n_res_size;
        r_res_excl <= n_res_excl;
    end

    // result beat
    assign o_out.valid         = (r_state == S_OUT);
    assign o_out.status        = r_status;
    assign o_out.res_id        = r_res_id;
    assign o_out.res_offset    = r_res_off;
    assign o_out.res_size      = r_res_size;
    assign o_out.res_exclusive = r_res_excl;
    assign o_out.available_bytes = (UW'(r_pool) > r_used) ? (r_pool - r_used[31:0]) : 32'd0;

    // assertions
    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !o_out.valid) else $error("result beat while idle");
    a_beat_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> r_state == S_CHECK) else $error("accepted item not validated");
    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_status == ST_OK && r_op != OP_RELEASE) |-> r_res_size != 32'd0)
        else $error("ok reserve with zero size");
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(tb_wr_en && tb_inv_en)) else $error("table write and release together");
endmodule
`default_nettype wire

// ----- test/tb_arena_reservation_table.sv -----
// Testbench for arena_reservation_table: directed table, then random traffic against a predictor.
`timescale 1ns / 100ps
module tb_arena_reservation_table;
    import art_pkg::*;

    localparam int  NUM_SLOTS  = ENTRIES_DEF;
    localparam int  DEF_ALIGN  = DEFAULT_ALIGN_DEF;
    localparam int  MAX_CYCLES = 3000000;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    // One result beat as the block should produce it.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] res_id;
        logic [31:0] res_offset;
        logic [31:0] res_size;
        logic        res_exclusive;
        logic [31:0] available_bytes;
    } t_result;

    // One request beat.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] req_size;
        logic [31:0] req_alignment;
        logic [31:0] req_offset;
        logic        req_exclusive;
        logic [31:0] release_id;
        logic        release_held;
    } t_request;

    // Directed row: either a pool size write or a request, with an optional
    // hand-typed result (otherwise the predictor supplies it).
    typedef struct packed {
        logic        is_cfg;
        logic [31:0] pool;
        t_request    req;
        logic        typed;
        t_result     res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    art_in_if  in_if ();
    art_out_if out_if ();
    art_cfg_if cfg_if ();

    arena_reservation_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // Shadow of the reservation table.
    logic [31:0] pool_bytes;
    logic        slot_live  [NUM_SLOTS];
    logic [31:0] slot_id    [NUM_SLOTS];
    logic [31:0] slot_start [NUM_SLOTS];
    logic [31:0] slot_len   [NUM_SLOTS];
    logic        slot_excl  [NUM_SLOTS];
    logic [31:0] id_counter;

    t_result pending_results[$];
    int      errors = 0;
    int      cycle_count = 0;
    int      tx_idle;        // sender idle percentage
    int      rx_idle;        // receiver idle percentage
    logic    rx_hold;        // long receiver hold-off in progress
    logic    rx_hold_go;

    // ------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("[arena_reservation_table] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_shadow(input logic [31:0] pool);
        pool_bytes = pool;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_live[i]  = 1'b0;
            slot_id[i]    = '0;
            slot_start[i] = '0;
            slot_len[i]   = '0;
            slot_excl[i]  = 1'b0;
        end
        id_counter = 32'd1;
    endfunction

    function automatic logic region_fits(input logic [63:0] at, input logic [63:0] len);
        return at <= {32'd0, pool_bytes} && len <= {32'd0, pool_bytes} - at;
    endfunction

    // Index of the first live slot overlapping [at, at+len), or -1.
    function automatic int first_overlap(input logic [63:0] at, input logic [63:0] len);
        logic [63:0] e_start;
        logic [63:0] e_end;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            e_start = {32'd0, slot_start[i]};
            e_end   = e_start + {32'd0, slot_len[i]};
            if (slot_live[i] && at < e_end && e_start < at + len) return i;
        end
        return -1;
    endfunction

    function automatic logic [31:0] free_byte_count();
        logic [63:0] used;
        used = '0;
        if (pool_bytes == 0) return '0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_live[i]) used += {32'd0, slot_len[i]};
        if (used >= {32'd0, pool_bytes}) return '0;
        return pool_bytes - used[31:0];
    endfunction

    function automatic t_result predict_reservation(input t_request rq);
        t_result     r;
        logic [63:0] align;
        logic [63:0] size;
        logic [63:0] at;
        logic        placed;
        int          hit;
        int          slot;
        r      = '0;
        r.status = ST_INVALID;
        size   = {32'd0, rq.req_size};
        align  = (rq.req_alignment == 0) ? 64'(DEF_ALIGN) : {32'd0, rq.req_alignment};
        if (rq.opcode == OP_FIRST || rq.opcode == OP_AT) begin
            if (pool_bytes == 0 || size == 0 || (align & (align - 1)) != 0) begin
                r.status = ST_INVALID;
            end else if (rq.opcode == OP_AT && ({32'd0, rq.req_offset} & (align - 1)) != 0) begin
                r.status = ST_INVALID;
            end else begin
                r.status = ST_NOSPACE;
                placed   = 1'b0;
                at       = '0;
                if (rq.opcode == OP_AT) begin
                    at     = {32'd0, rq.req_offset};
                    placed = region_fits(at, size) && first_overlap(at, size) < 0;
                end else begin
                    // First fit: hop past each blocking entry, aligned up.
                    for (int p = 0; p <= NUM_SLOTS && region_fits(at, size); p++) begin
                        hit = first_overlap(at, size);
                        if (hit < 0) begin
                            placed = 1'b1;
                            break;
                        end
                        at = {32'd0, slot_start[hit]} + {32'd0, slot_len[hit]};
                        at = (at + align - 1) & ~(align - 1);
                    end
                end
                if (placed) begin
                    slot = -1;
                    for (int i = NUM_SLOTS - 1; i >= 0; i--)
                        if (!slot_live[i]) slot = i;
                    if (slot < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        slot_live[slot]  = 1'b1;
                        slot_id[slot]    = id_counter;
                        slot_start[slot] = at[31:0];
                        slot_len[slot]   = rq.req_size;
                        slot_excl[slot]  = rq.req_exclusive;
                        r.status         = ST_OK;
                        r.res_id         = id_counter;
                        r.res_offset     = at[31:0];
                        r.res_size       = rq.req_size;
                        r.res_exclusive  = rq.req_exclusive;
                        id_counter       = id_counter + 32'd1;
                    end
                end
            end
        end else if (rq.opcode == OP_RELEASE && rq.release_held) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (slot_live[i] && slot_id[i] == rq.release_id) begin
                    slot_live[i] = 1'b0;
                    r.status     = ST_OK;
                    break;
                end
            end
        end
        r.available_bytes = free_byte_count();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Drive one request; at acceptance, predict and queue its result.
    task automatic send_request(input t_request rq, input logic typed, input t_result typed_res);
        t_result r;
        while ($urandom_range(99) < tx_idle) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.opcode        <= rq.opcode;
        in_if.req_size      <= rq.req_size;
        in_if.req_alignment <= rq.req_alignment;
        in_if.req_offset    <= rq.req_offset;
        in_if.req_exclusive <= rq.req_exclusive;
        in_if.release_id    <= rq.release_id;
        in_if.release_held  <= rq.release_held;
        do @(posedge i_clk); while (!in_if.ready);
        r = predict_reservation(rq);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    // Pool size write, only with the block drained.
    task automatic write_pool(input logic [31:0] pool);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.pool_size <= pool;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        clear_shadow(pool);
        @(posedge i_clk);
    endtask

    function automatic t_request random_request();
        t_request    rq;
        logic [31:0] lim;
        int          pick;
        int          n;
        rq  = '0;
        lim = (pool_bytes == 0) ? 32'd64 : ((pool_bytes / 6 == 0) ? 32'd1 : pool_bytes / 6);
        pick = $urandom_range(99);
        rq.opcode = (pick < 40) ? OP_FIRST : (pick < 65) ? OP_AT :
                    (pick < 95) ? OP_RELEASE : OP_UNKNOWN;
        pick = $urandom_range(99);
        rq.req_size = (pick < 4) ? 32'd0 : (pick < 9) ? $urandom() : $urandom_range(lim, 1);
        pick = $urandom_range(99);
        rq.req_alignment = (pick < 50) ? 32'd0 :
                           (pick < 85) ? (32'd1 << $urandom_range(6)) :
                           (pick < 91) ? (32'd1 << $urandom_range(31)) : $urandom();
        pick = $urandom_range(99);
        if (pick < 75) begin
            rq.req_offset = $urandom_range(pool_bytes);
            if (rq.req_alignment == 0) rq.req_offset &= ~32'(DEF_ALIGN - 1);
            else rq.req_offset &= ~(rq.req_alignment - 1);
        end else begin
            rq.req_offset = $urandom();
        end
        rq.req_exclusive = $urandom_range(1);
        // Releases mostly target a live id.
        n = 0;
        rq.release_id = $urandom();
        if ($urandom_range(99) < 80) begin
            for (int i = 0; i < NUM_SLOTS; i++)
                if (slot_live[i] && $urandom_range(n) == 0) begin
                    rq.release_id = slot_id[i];
                    n++;
                end
        end
        rq.release_held = ($urandom_range(99) < 90);
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) out_if.ready <= 1'b0;
        else out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle);
    end

    // Long hold-off so the block fills and stalls its input.
    initial begin
        rx_hold = 1'b0;
        wait (rx_hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (out_if.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, out_if.status);
                    errors++;
                end
                if (out_if.res_id !== want.res_id) begin
                    $error("res_id exp %0h got %0h", want.res_id, out_if.res_id);
                    errors++;
                end
                if (out_if.res_offset !== want.res_offset) begin
                    $error("res_offset exp %0h got %0h", want.res_offset, out_if.res_offset);
                    errors++;
                end
                if (out_if.res_size !== want.res_size) begin
                    $error("res_size exp %0h got %0h", want.res_size, out_if.res_size);
                    errors++;
                end
                if (out_if.res_exclusive !== want.res_exclusive) begin
                    $error("res_exclusive exp %0d got %0d", want.res_exclusive,
                           out_if.res_exclusive);
                    errors++;
                end
                if (out_if.available_bytes !== want.available_bytes) begin
                    $error("available_bytes exp %0h got %0h", want.available_bytes,
                           out_if.available_bytes);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    localparam int NUM_ROWS = 22;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        // pool zero: reserves are refused
        '{1'b0, 32'd0, '{OP_FIRST, 32'd8, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0},
          1'b1, '{ST_INVALID, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0}},
        '{1'b0, 32'd0, '{OP_UNKNOWN, 32'd8, 32'd0, 32'd0, 1'b0, 32'd0, 1'b1},
          1'b1, '{ST_INVALID, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0}},
        '{1'b1, 32'd1024, '0, 1'b0, '0},
        '{1'b0, 32'd0, '{OP_FIRST, 32'd16, 32'd0, 32'd0, 1'b1, 32'd0, 1'b0},
          1'b1, '{ST_OK, 32'd1, 32'd0, 32'd16, 1'b1, 32'd1008}},
        // alignment not a power of two
        '{1'b0, 32'd0, '{OP_FIRST, 32'd1, 32'd3, 32'd0, 1'b0, 32'd0, 1'b0},
          1'b1, '{ST_INVALID, 32'd0, 32'd0, 32'd0, 1'b0, 32'd1008}},
        // misaligned fixed offset
        '{1'b0, 32'd0, '{OP_AT, 32'd8, 32'd8, 32'd4, 1'b0, 32'd0, 1'b0},
          1'b1, '{ST_INVALID, 32'd0, 32'd0, 32'd0, 1'b0, 32'd1008}},
        '{1'b0, 32'd0, '{OP_AT, 32'd16, 32'd16, 32'd32, 1'b0, 32'd0, 1'b0}, 1'b0, '0},
        '{1'b0, 32'd0, '{OP_FIRST, 32'd8, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0}, 1'b0, '0},
        '{1'b0, 32'd0, '{OP_FIRST, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0}, 1'b0, '0},
        '{1'b0, 32'd0, '{OP_FIRST, 32'd2000, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0}, 1'b0, '0},
        '{1'b0, 32'd0, '{OP_FIRST, 32'd8, 32'h8000_0000, 32'd0, 1'b1, 32'd0, 1'b0},
          1'b0, '0},
        // releases: a miss when not held, a miss on an unknown id, then a hit on a live id
        '{1'b0, 32'd0, '{OP_RELEASE, 32'd0, 32'd0, 32'd0, 1'b0, 32'd1, 1'b0}, 1'b0, '0},
        '{1'b0, 32'd0, '{OP_RELEASE, 32'd0, 32'd0, 32'd0, 1'b0, 32'd99, 1'b1}, 1'b0, '0},
        '{1'b0, 32'd0, '{OP_RELEASE, 32'd0, 32'd0, 32'd0, 1'b0, 32'd1, 1'b1}, 1'b0, '0},
        '{1'b0, 32'd0, '{OP_UNKNOWN, '1, '1, '1, 1'b1, '1, 1'b1}, 1'b0, '0},
        '{1'b0, 32'd0, '{OP_AT, '1, 32'd0, 32'hFFFF_FFF8, 1'b0, 32'd0, 1'b0}, 1'b0, '0},
        '{1'b1, 32'hFFFF_FFFF, '0, 1'b0, '0},
        '{1'b0, 32'd0, '{OP_AT, '1, 32'd1, 32'd0, 1'b1, 32'd0, 1'b0},
          1'b1, '{ST_OK, 32'd1, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'd0}},
        '{1'b0, 32'd0, '{OP_FIRST, 32'd1, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0}, 1'b0, '0},
        '{1'b0, 32'd0, '{OP_RELEASE, 32'd0, 32'd0, 32'd0, 1'b0, 32'd1, 1'b1},
          1'b1, '{ST_OK, 32'd0, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF}},
        '{1'b0, 32'd0, '{OP_FIRST, '1, 32'h8000_0000, 32'd0, 1'b0, 32'd0, 1'b0}, 1'b0, '0},
        '{1'b1, 32'd1, '0, 1'b0, '0}
    };

    // Pool sizes for the random phases: tiny to full range.
    localparam int NUM_PHASES = 9;
    localparam logic [31:0] PHASE_POOLS [NUM_PHASES] = '{
        32'd1, 32'd64, 32'd256, 32'd1024, 32'd4096, 32'd65536,
        32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int item_count;
        int per_phase;
        in_if.valid         = 1'b0;
        in_if.opcode        = OP_FIRST;
        in_if.req_size      = '0;
        in_if.req_alignment = '0;
        in_if.req_offset    = '0;
        in_if.req_exclusive = 1'b0;
        in_if.release_id    = '0;
        in_if.release_held  = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.pool_size    = '0;
        rx_hold_go          = 1'b0;
        tx_idle             = 21;
        rx_idle             = 69;
        clear_shadow(32'd0);

        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NUM_ROWS; k++) begin
            if (DIRECTED[k].is_cfg) write_pool(DIRECTED[k].pool);
            else send_request(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].res);
        end

        item_count = 0;
        per_phase  = 84;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_pool(ph == 6 ? $urandom() : PHASE_POOLS[ph]);
            for (int j = 0; j < per_phase; j++) begin
                // idle profile: sender light / receiver heavy, then swapped, then none
                if (item_count < 250) begin
                    tx_idle = 21; rx_idle = 69;
                end else if (item_count < 500) begin
                    tx_idle = 69; rx_idle = 21;
                end else begin
                    tx_idle = 0;  rx_idle = 0;
                end
                if (item_count == 100) rx_hold_go = 1'b1;
                if (item_count == 400) begin
                    // sender pause: drain everything before going on
                    in_if.valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
                send_request(random_request(), 1'b0, '0);
                item_count++;
            end
        end
        in_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("[arena_reservation_table] OK");
        end else begin
            $display("[arena_reservation_table] ERROR");
        end
        $finish;
    end
endmodule
